// File: sv/lcs_pkg.sv
// ---------------------------------------------------------------------------
// Layer command sequencer package
// Shared widths, codes, state types and the phase-advance functions.
// ---------------------------------------------------------------------------
package lcs_pkg;

    localparam int GROUP     = 4;
    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 10;
    localparam int MASK_W    = 8;
    localparam int SLOT_W    = 3;
    localparam int GC_W      = 10;
    localparam int SPAN_W    = GC_W + SLOT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OP_W      = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PREACT_BASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_MASK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_MODE  = 3'd7;

    typedef enum logic [OP_W-1:0] {
        OP_MATMUL = 2'd0,
        OP_MOVE   = 2'd1,
        OP_NOP    = 2'd2,
        OP_DONE   = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        PH_MATMUL   = 5'b00001,
        PH_MOVE_OUT = 5'b00010,
        PH_NOP      = 5'b00100,
        PH_MOVE_PRE = 5'b01000,
        PH_DONE     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0] weight_base;
        logic [ADDR_W-1:0] input_base;
        logic [LEN_W-1:0]  input_len;
        logic [ADDR_W-1:0] output_base;
        logic [LEN_W-1:0]  output_len;
        logic [ADDR_W-1:0] preact_base;
        logic [MASK_W-1:0] act_mask;
        logic              train_mode;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [ADDR_W-1:0] weight_ptr;
        logic [LEN_W-1:0]  input_count;
        logic [ADDR_W-1:0] output_ptr;
        logic [ADDR_W-1:0] preact_ptr;
        logic [SLOT_W-1:0] slot_count;
        logic [GC_W-1:0]   group_count;
    } seq_t;

    // Output moves left in this group.
    function automatic logic out_open(seq_t s, cfg_t c);
        logic [ADDR_W-1:0] diff;
        diff = s.output_ptr - c.output_base;
        return (s.slot_count < SLOT_W'(GROUP)) && (diff < ADDR_W'(c.output_len));
    endfunction

    // Pre-activation moves left in this group.
    function automatic logic pre_open(seq_t s, cfg_t c);
        logic [ADDR_W-1:0] diff;
        diff = s.preact_ptr - c.preact_base;
        return (s.slot_count < SLOT_W'(GROUP)) && (diff < ADDR_W'(c.output_len));
    endfunction

    // Step to the next group and settle its first phase. With no inputs and
    // no output moves left outside training, every later group is empty as
    // well, so the layer ends at once.
    function automatic seq_t next_group(seq_t s, cfg_t c);
        seq_t             r;
        logic [GC_W-1:0]  gc1;
        logic [SPAN_W-1:0] span;
        r    = s;
        gc1  = s.group_count + 1'b1;
        span = SPAN_W'(gc1) * SPAN_W'(GROUP);
        r.group_count = gc1;
        if (span >= SPAN_W'(c.output_len)) begin
            r.phase = PH_DONE;
        end else begin
            r.input_count = '0;
            r.slot_count  = '0;
            if (c.input_len != '0) begin
                r.phase = PH_MATMUL;
            end else if (out_open(r, c)) begin
                r.phase = PH_MOVE_OUT;
            end else if (c.train_mode) begin
                r.phase = PH_NOP;
            end else begin
                r.phase = PH_DONE;
            end
        end
        return r;
    endfunction

    // Skip over phases that have nothing left to issue.
    function automatic seq_t settle(seq_t s, cfg_t c);
        seq_t r;
        r = s;
        if (r.phase == PH_MATMUL && r.input_count >= c.input_len) begin
            r.phase      = PH_MOVE_OUT;
            r.slot_count = '0;
        end
        if (r.phase == PH_MOVE_OUT && !out_open(r, c)) begin
            if (c.train_mode) begin
                r.phase = PH_NOP;
            end else begin
                r = next_group(r, c);
            end
        end
        if (r.phase == PH_NOP && r.slot_count >= SLOT_W'(GROUP)) begin
            r.phase      = PH_MOVE_PRE;
            r.slot_count = '0;
        end
        if (r.phase == PH_MOVE_PRE && !pre_open(r, c)) begin
            r = next_group(r, c);
        end
        return r;
    endfunction

endpackage

// File: sv/layer_command_sequencer_core.sv
// A request waits in the input register until the result register is empty or taken.
// Throughput: one command per cycle while m_tready holds; the input register and
// the result register let a new request enter while the previous command waits to be taken.
// Reset: the configuration, the sequencing state and both valid flags clear, the
// sequence sits at done, and every request before the first restart returns a done record.
// ---------------------------------------------------------------------------
// Layer command sequencer core
// Issues one matmul, move, nop or done command per request for a dense layer
// processed in groups of neurons.
// ---------------------------------------------------------------------------
module layer_command_sequencer_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    // requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [0] restart, [7:1] zero
    // commands
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,  // [15:0] addr_a, [31:16] addr_b,
                                                      // [32] bypass, [40:33] mask_out,
                                                      // [47:41] zero
    output logic [1:0]                      m_tuser,  // [1:0] opcode
    output logic                            m_tlast
);
    import lcs_pkg::*;

    cfg_t              cfg_reg;
    seq_t              seq_reg;
    seq_t              seq_next;
    logic              in_valid_reg;
    logic              restart_reg;
    logic              out_valid_reg;
    opcode_t           op_reg;
    opcode_t           op_next;
    logic [ADDR_W-1:0] addr_a_reg;
    logic [ADDR_W-1:0] addr_a_next;
    logic [ADDR_W-1:0] addr_b_reg;
    logic [ADDR_W-1:0] addr_b_next;
    logic              bypass_reg;
    logic              bypass_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              last_reg;
    logic              last_next;
    logic              advance;
    seq_t              start;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WEIGHT_BASE: cfg_reg.weight_base <= cfg_data;
                REG_INPUT_BASE:  cfg_reg.input_base  <= cfg_data;
                REG_INPUT_LEN:   cfg_reg.input_len   <= cfg_data[LEN_W-1:0];
                REG_OUTPUT_BASE: cfg_reg.output_base <= cfg_data;
                REG_OUTPUT_LEN:  cfg_reg.output_len  <= cfg_data[LEN_W-1:0];
                REG_PREACT_BASE: cfg_reg.preact_base <= cfg_data;
                REG_ACT_MASK:    cfg_reg.act_mask    <= cfg_data[MASK_W-1:0];
                REG_TRAIN_MODE:  cfg_reg.train_mode  <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        seq_t s;
        s = seq_reg;
        if (restart_reg) begin
            s.weight_ptr  = cfg_reg.weight_base;
            s.output_ptr  = cfg_reg.output_base;
            s.preact_ptr  = cfg_reg.preact_base;
            s.input_count = '0;
            s.slot_count  = '0;
            s.group_count = '0;
            s.phase       = (cfg_reg.output_len == '0) ? PH_DONE : PH_MATMUL;
            s = settle(s, cfg_reg);
        end
        start = s;
    end

    always_comb
    begin
        seq_next    = start;
        op_next     = OP_DONE;
        addr_a_next = '0;
        addr_b_next = '0;
        bypass_next = 1'b0;
        mask_next   = '0;
        last_next   = 1'b0;
        unique case (start.phase)
            PH_MATMUL:
            begin
                op_next              = OP_MATMUL;
                addr_a_next          = start.weight_ptr;
                addr_b_next          = cfg_reg.input_base + ADDR_W'(start.input_count);
                seq_next.weight_ptr  = start.weight_ptr + 1'b1;
                seq_next.input_count = start.input_count + 1'b1;
            end
            PH_MOVE_OUT:
            begin
                op_next             = OP_MOVE;
                addr_a_next         = start.output_ptr;
                bypass_next         = 1'b1;
                mask_next           = cfg_reg.act_mask;
                seq_next.output_ptr = start.output_ptr + 1'b1;
                seq_next.slot_count = start.slot_count + 1'b1;
            end
            PH_NOP:
            begin
                op_next             = OP_NOP;
                seq_next.slot_count = start.slot_count + 1'b1;
            end
            PH_MOVE_PRE:
            begin
                op_next             = OP_MOVE;
                addr_a_next         = start.preact_ptr;
                bypass_next         = 1'b1;
                mask_next           = cfg_reg.act_mask;
                seq_next.preact_ptr = start.preact_ptr + 1'b1;
                seq_next.slot_count = start.slot_count + 1'b1;
            end
            PH_DONE:
            begin
                op_next = OP_DONE;
            end
            default:
            begin
                op_next = OP_DONE;
            end
        endcase
        if (op_next != OP_DONE) begin
            seq_next  = settle(seq_next, cfg_reg);
            last_next = (seq_next.phase == PH_DONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg.phase       <= PH_DONE;
            seq_reg.weight_ptr  <= '0;
            seq_reg.input_count <= '0;
            seq_reg.output_ptr  <= '0;
            seq_reg.preact_ptr  <= '0;
            seq_reg.slot_count  <= '0;
            seq_reg.group_count <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                seq_reg       <= seq_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            restart_reg <= s_tdata[0];
        end
        if (advance) begin
            op_reg     <= op_next;
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
            bypass_reg <= bypass_next;
            mask_reg   <= mask_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, mask_reg, bypass_reg, addr_b_reg, addr_a_reg};
    assign m_tuser  = op_reg;
    assign m_tlast  = last_reg;

endmodule
